/* hdl/mdc_pkg.sv */
// ---------------------------------------------------------------------------
// mdc_pkg - shared types and constants for the modulated delay chorus
// Controller/datapath command and status groups, sine polynomial
// coefficients, register indexes and register reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

    // Field widths fixed by the stream format
    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 3;
    localparam int CFG_W    = 22;
    localparam int CFG_IDX_W = 2;

    // Register widths
    localparam int STEP_W  = 22;
    localparam int DELAY_W = 19;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWING      = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 22'd89478;
    localparam logic [DELAY_W-1:0] BASE_DELAY_RST = 19'd98304;
    localparam logic [DELAY_W-1:0] SWING_RST      = 19'd36864;

    // Quarter turn of the LFO phase (odd channels lead by 90 degrees)
    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

    // Sine polynomial coefficients, Q15
    localparam logic [14:0] SIN_C1 = 15'd21167;
    localparam logic [11:0] SIN_C2 = 12'd2463;
    localparam logic [15:0] SIN_C3 = 16'd51472;
    localparam logic [15:0] SIN_ONE = 16'd32768;

    // Controller states
    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_SQ    = 12'b0000_0000_0100,
        S_POLYT = 12'b0000_0000_1000,
        S_POLYU = 12'b0000_0001_0000,
        S_SINE  = 12'b0000_0010_0000,
        S_MOD   = 12'b0000_0100_0000,
        S_DLY   = 12'b0000_1000_0000,
        S_POS   = 12'b0001_0000_0000,
        S_READ  = 12'b0010_0000_0000,
        S_MIX   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    // Commands from controller to datapath, one step per bit
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic sq_step;
        logic t_step;
        logic u_step;
        logic s_step;
        logic mod_step;
        logic dly_step;
        logic pos_step;
        logic read_step;
        logic mix_step;
        logic finish;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic ch_ok;
    } status_t;

endpackage

`default_nettype wire

/* hdl/modulated_delay_chorus.sv */
// ---------------------------------------------------------------------------
// modulated_delay_chorus - LFO modulated delay chorus on interleaved samples
// Input stream s_axis: tdata = sample, tuser = channel, tlast = frame end.
// Output stream m_axis: tdata = dry + wet/2 saturated, tuser/tlast passed on.
// Config port: cfg_we/cfg_index/cfg_data write phase_step (0), base delay
// (1) and swing (2); write only while the block is idle.
// Sequence: the sequencer steps a sample of a valid channel in order through
// the sine polynomial, modulation, delay clamp, read position, ring read
// and mix; no new sample is accepted until its result has been loaded
// into the output register.
// Samples of channels not below CHANNELS skip these steps.
// Reset: the ring memory is cleared one entry per cycle, CHANNELS *
// 2^ceil(log2(DELAY_DEPTH)) entries (8192 by default), with s_axis_tready
// low; config writes are taken during that pass.
// Stall: a finished result waits in the output register; the next sample
// is accepted and worked on, and holds in its last step until the output
// register is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module modulated_delay_chorus #(
    parameter int CHANNELS    = 2,
    parameter int DELAY_DEPTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,   // [15:0] in_sample
    input  wire logic [2:0]                    s_axis_tuser,   // [2:0] channel
    input  wire logic                          s_axis_tlast,   // frame_end
    // result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // [15:0] out_sample
    output logic [2:0]                         m_axis_tuser,   // [2:0] out_channel
    output logic                               m_axis_tlast,   // out_frame_end
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [mdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mdc_pkg::CFG_W-1:0]     cfg_data
);
    import mdc_pkg::*;

    cmd_t    cmd;
    status_t status;

    mdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mdc_datapath #(
        .CHANNELS    (CHANNELS),
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_sample     (s_axis_tdata),
        .in_channel    (s_axis_tuser),
        .in_frame_end  (s_axis_tlast),
        .out_sample    (m_axis_tdata),
        .out_channel   (m_axis_tuser),
        .out_frame_end (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* hdl/mdc_ctrl.sv */
// ---------------------------------------------------------------------------
// mdc_ctrl - sequencer for the modulated delay chorus
// Runs the ring clearing pass after reset, then steps each accepted item of a
// valid channel through the sine, delay, ring read and mix datapath steps.
// ---------------------------------------------------------------------------
`default_nettype none

module mdc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire mdc_pkg::status_t status,
    output mdc_pkg::cmd_t         cmd
);
    import mdc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   load_out;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == S_IDLE);
    // result may go to the output register once it is free or being emptied
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (status.clr_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.ch_ok ? S_SQ : S_DONE;
                end
            end
            S_SQ:    state_next = S_POLYT;
            S_POLYT: state_next = S_POLYU;
            S_POLYU: state_next = S_SINE;
            S_SINE:  state_next = S_MOD;
            S_MOD:   state_next = S_DLY;
            S_DLY:   state_next = S_POS;
            S_POS:   state_next = S_READ;
            S_READ:  state_next = S_MIX;
            S_MIX:   state_next = S_DONE;
            S_DONE:  if (load_out) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.clr_step  = (state_reg == S_CLEAR);
        cmd.capture   = accept;
        cmd.sq_step   = (state_reg == S_SQ);
        cmd.t_step    = (state_reg == S_POLYT);
        cmd.u_step    = (state_reg == S_POLYU);
        cmd.s_step    = (state_reg == S_SINE);
        cmd.mod_step  = (state_reg == S_MOD);
        cmd.dly_step  = (state_reg == S_DLY);
        cmd.pos_step  = (state_reg == S_POS);
        cmd.read_step = (state_reg == S_READ);
        cmd.mix_step  = (state_reg == S_MIX);
        cmd.finish    = load_out;
    end

    // Output valid flag
    always_comb
    begin
        priority if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/mdc_datapath.sv */
// ---------------------------------------------------------------------------
// mdc_datapath - arithmetic and storage of the modulated delay chorus
// Config registers, LFO phase, sine polynomial, delay computation, delay
// rings in one memory, per-channel write pointers and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mdc_datapath #(
    parameter int CHANNELS    = 2,
    parameter int DELAY_DEPTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mdc_pkg::cmd_t                 cmd,
    output mdc_pkg::status_t                   status,
    input  wire logic                          cfg_we,
    input  wire logic [mdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mdc_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [mdc_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire logic [mdc_pkg::CHAN_W-1:0]    in_channel,
    input  wire logic                          in_frame_end,
    output logic [mdc_pkg::SAMPLE_W-1:0]       out_sample,
    output logic [mdc_pkg::CHAN_W-1:0]         out_channel,
    output logic                               out_frame_end
);
    import mdc_pkg::*;

    localparam int DW        = $clog2(DELAY_DEPTH);
    localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW        = CHW + DW;
    localparam int MEM_DEPTH = CHANNELS * (2 ** DW);
    localparam int QW        = DW + 8;
    localparam int DLW       = (DW + 10 > 23) ? DW + 10 : 23;

    localparam logic [DW-1:0]         WP_LAST   = DW'(DELAY_DEPTH - 1);
    localparam logic [AW-1:0]         CLR_LAST  = AW'(MEM_DEPTH - 1);
    localparam logic signed [DLW-1:0] D_MIN     = DLW'(256);
    localparam logic signed [DLW-1:0] D_MAX     = DLW'((DELAY_DEPTH - 2) * 256);
    localparam logic [QW:0]           RING_Q8   = (QW + 1)'(DELAY_DEPTH * 256);

    // Configuration registers
    logic [STEP_W-1:0]  step_reg;
    logic [DELAY_W-1:0] base_reg;
    logic [DELAY_W-1:0] swing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= PHASE_STEP_RST;
            base_reg  <= BASE_DELAY_RST;
            swing_reg <= SWING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP: step_reg  <= cfg_data[STEP_W-1:0];
                REG_BASE_DELAY: base_reg  <= cfg_data[DELAY_W-1:0];
                REG_SWING:      swing_reg <= cfg_data[DELAY_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control state: LFO phase, write pointers, clearing counter
    logic [31:0]   phase_reg;
    logic [DW-1:0] wp_reg [CHANNELS];
    logic [AW-1:0] clr_cnt_reg;

    // Captured item
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic [CHAN_W-1:0]          ch_reg;
    logic                       fe_reg;
    logic                       ch_ok_reg;
    logic [CHW-1:0]             chi;

    // Arithmetic pipeline registers
    logic [15:0]               x_reg;
    logic                      neg_reg;
    logic [15:0]               x2_reg;
    logic [14:0]               t_reg;
    logic [15:0]               u_reg;
    logic signed [15:0]        lfo_reg;
    logic signed [20:0]        mod_reg;
    logic [QW-1:0]             d_reg;
    logic [QW-1:0]             rpos_reg;
    logic signed [SAMPLE_W-1:0] rd0_reg;
    logic signed [SAMPLE_W-1:0] rd1_reg;
    logic [7:0]                frac_reg;
    logic signed [25:0]        p0_reg;
    logic signed [25:0]        p1_reg;

    // Output register
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [CHAN_W-1:0]   out_ch_reg;
    logic                out_fe_reg;

    // Ring memory
    logic signed [SAMPLE_W-1:0] ring_mem [MEM_DEPTH];

    logic        ch_ok_in;
    logic [31:0] phase_p;
    logic [14:0] frac_f;
    logic [15:0] x_next;

    assign chi = ch_reg[CHW-1:0];
    assign ch_ok_in = (32'(in_channel) < CHANNELS);
    assign status.ch_ok    = ch_ok_in;
    assign status.clr_last = (clr_cnt_reg == CLR_LAST);

    // Folded sine argument from the phase, odd channels a quarter turn ahead
    always_comb
    begin
        phase_p = phase_reg + (in_channel[0] ? PHASE_QUARTER : 32'd0);
        frac_f  = phase_p[29:15];
        x_next  = phase_p[30] ? (SIN_ONE - {1'b0, frac_f}) : {1'b0, frac_f};
    end

    // Polynomial products
    logic [31:0]        sq_prod;
    logic [27:0]        t_prod;
    logic [30:0]        u_prod;
    logic [31:0]        s_prod;
    logic [14:0]        s_clip;
    logic signed [35:0] m_prod;

    always_comb
    begin
        sq_prod = x_reg * x_reg;
        t_prod  = SIN_C2 * x2_reg;
        u_prod  = t_reg * x2_reg;
        s_prod  = x_reg * u_reg;
        s_clip  = (s_prod[31:15] > 17'd32767) ? 15'h7FFF : s_prod[29:15];
        m_prod  = lfo_reg * $signed({1'b0, swing_reg});
    end

    // Delay sum and clamp
    logic signed [DLW-1:0] d_sum;
    logic [QW-1:0]         d_next;

    always_comb
    begin
        d_sum = $signed(DLW'(base_reg)) + DLW'(mod_reg);
        priority if (d_sum < D_MIN)
            d_next = QW'(D_MIN);
        else if (d_sum > D_MAX)
            d_next = QW'(D_MAX);
        else
            d_next = d_sum[QW-1:0];
    end

    // Read position behind the write pointer, wrapped into the ring
    logic [QW:0]   r_diff;
    logic [QW:0]   r_wrap;

    always_comb
    begin
        r_diff = {1'b0, wp_reg[chi], 8'b0} - {1'b0, d_reg};
        r_wrap = r_diff[QW] ? (r_diff + RING_Q8) : r_diff;
    end

    // Tap indexes
    logic [DW-1:0] i0;
    logic [DW-1:0] i1;

    always_comb
    begin
        i0 = rpos_reg[QW-1:8];
        i1 = (i0 == WP_LAST) ? '0 : i0 + DW'(1);
    end

    // Final mix and saturation; wet part floored, sign kept
    logic signed [26:0] w_sum;
    logic signed [18:0] o_sum;
    logic [SAMPLE_W-1:0] o_sat;

    always_comb
    begin
        w_sum = 27'(p0_reg) + 27'(p1_reg);
        o_sum = 19'(samp_reg) + 19'($signed(w_sum[26:9]));
        priority if (o_sum > 19'sd32767)
            o_sat = 16'h7FFF;
        else if (o_sum < -19'sd32768)
            o_sat = 16'h8000;
        else
            o_sat = o_sum[15:0];
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            clr_cnt_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.finish)
            begin
                if (fe_reg)
                begin
                    phase_reg <= phase_reg + 32'(step_reg);
                end
                if (ch_ok_reg)
                begin
                    wp_reg[chi] <= (wp_reg[chi] == WP_LAST) ? '0 : wp_reg[chi] + DW'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            samp_reg  <= $signed(in_sample);
            ch_reg    <= in_channel;
            fe_reg    <= in_frame_end;
            ch_ok_reg <= ch_ok_in;
            x_reg     <= x_next;
            neg_reg   <= phase_p[31];
        end
        if (cmd.sq_step)
        begin
            x2_reg <= sq_prod[30:15];
        end
        if (cmd.t_step)
        begin
            t_reg <= SIN_C1 - {2'b0, t_prod[27:15]};
        end
        if (cmd.u_step)
        begin
            u_reg <= SIN_C3 - u_prod[30:15];
        end
        if (cmd.s_step)
        begin
            lfo_reg <= neg_reg ? -$signed({1'b0, s_clip}) : $signed({1'b0, s_clip});
        end
        if (cmd.mod_step)
        begin
            mod_reg <= m_prod[35:15];
        end
        if (cmd.dly_step)
        begin
            d_reg <= d_next;
        end
        if (cmd.pos_step)
        begin
            rpos_reg <= r_wrap[QW-1:0];
        end
        if (cmd.read_step)
        begin
            frac_reg <= rpos_reg[7:0];
        end
        if (cmd.mix_step)
        begin
            p0_reg <= rd0_reg * $signed({1'b0, 9'(9'd256 - {1'b0, frac_reg})});
            p1_reg <= rd1_reg * $signed({2'b0, frac_reg});
        end
        if (cmd.finish)
        begin
            out_sample_reg <= ch_ok_reg ? o_sat : samp_reg;
            out_ch_reg     <= ch_reg;
            out_fe_reg     <= fe_reg;
        end
    end

    // Ring memory: clearing pass or input write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            ring_mem[clr_cnt_reg] <= '0;
        else if (cmd.finish && ch_ok_reg)
            ring_mem[{chi, wp_reg[chi]}] <= samp_reg;
        if (cmd.read_step)
        begin
            rd0_reg <= ring_mem[{chi, i0}];
            rd1_reg <= ring_mem[{chi, i1}];
        end
    end

    assign out_sample    = out_sample_reg;
    assign out_channel   = out_ch_reg;
    assign out_frame_end = out_fe_reg;

endmodule

`default_nettype wire

/* tb/tb_modulated_delay_chorus.sv */
// ---------------------------------------------------------------------------
// tb_modulated_delay_chorus - self-checking bench for the chorus block
// Streams interleaved samples into the block with random idle gaps and
// random output stalls. Every accepted item of a live channel runs through a
// local model of the LFO, the clamped fractional delay, the ring read and the
// mix. Each result is then compared, field by field, with the oldest
// expectation. Directed tests cover the defaults, pass-through channels,
// saturation and the delay clamps. A long run of frame ends at the largest
// step sweeps the LFO phase fast. Randomized traffic then runs under several
// register settings.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_modulated_delay_chorus;

    timeunit 1ns;
    timeprecision 1ps;

    import mdc_pkg::*;

    localparam int CHANNELS    = 2;
    localparam int DELAY_DEPTH = 4096;
    localparam longint DELAY_MIN_Q8 = 256;
    localparam longint DELAY_MAX_Q8 = longint'(DELAY_DEPTH - 2) * 256;
    localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
    // index past the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   channel;
        logic                frame_end;
    } chorus_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [15:0] in_sample
    logic [2:0]           s_axis_tuser;   // [2:0] channel
    logic                 s_axis_tlast;   // frame_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // [15:0] out_sample
    logic [2:0]           m_axis_tuser;   // [2:0] out_channel
    logic                 m_axis_tlast;   // out_frame_end
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // model state
    bit signed [SAMPLE_W-1:0] delay_ring [CHANNELS][DELAY_DEPTH];
    int                       wr_ptr [CHANNELS];
    bit [31:0]                lfo_acc;
    bit [STEP_W-1:0]          step_cfg  = PHASE_STEP_RST;
    bit [DELAY_W-1:0]         base_cfg  = BASE_DELAY_RST;
    bit [DELAY_W-1:0]         swing_cfg = SWING_RST;

    chorus_item_t pending_mix_q[$];

    int error_count     = 0;
    int items_sent      = 0;
    int live_items      = 0;
    int results_checked = 0;
    int settings_loaded = 0;
    int phase_wraps     = 0;
    int feed_gap_pct    = 0;
    int sink_stall_pct  = 0;

    modulated_delay_chorus #(
        .CHANNELS    (CHANNELS),
        .DELAY_DEPTH (DELAY_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return $urandom_range(0, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom_range(2000)) - 16'd1000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Q15 sine of the phase, polynomial on a quarter turn
    function automatic int lfo_sine(logic [31:0] p);
        longint x, x2, t, u, s;
        x = longint'(p[29:15]);
        if (p[31:30] == 2'd1 || p[31:30] == 2'd3)
            x = longint'(SIN_ONE) - x;
        x2 = (x * x) >> 15;
        t = longint'(SIN_C1) - ((longint'(SIN_C2) * x2) >> 15);
        u = longint'(SIN_C3) - ((t * x2) >> 15);
        s = (x * u) >> 15;
        if (s > 32767)
            s = 32767;
        return (p[31:30] < 2'd2) ? int'(s) : -int'(s);
    endfunction

    // expected result of one accepted item; updates ring, pointer and phase
    function automatic void predict_chorus(logic [15:0] smp, logic [2:0] ch, logic fe);
        chorus_item_t res;
        int           lfo, wp, i0, i1, frac;
        longint       dly, rpos, wet, mix;
        bit [32:0]    acc_next;
        res.sample    = smp;
        res.channel   = ch;
        res.frame_end = fe;
        if (ch < CHANNELS)
        begin
            lfo = lfo_sine(lfo_acc + (ch[0] ? PHASE_QUARTER : 32'd0));
            dly = longint'(base_cfg) + ((longint'(lfo) * longint'(swing_cfg)) >>> 15);
            if (dly < DELAY_MIN_Q8)
                dly = DELAY_MIN_Q8;
            if (dly > DELAY_MAX_Q8)
                dly = DELAY_MAX_Q8;
            wp = wr_ptr[ch];
            rpos = longint'(wp) * 256 - dly;
            if (rpos < 0)
                rpos += longint'(DELAY_DEPTH) * 256;
            i0   = int'(rpos >> 8) % DELAY_DEPTH;
            i1   = (i0 + 1) % DELAY_DEPTH;
            frac = int'(rpos & 255);
            wet  = longint'(delay_ring[ch][i0]) * (256 - frac) +
                   longint'(delay_ring[ch][i1]) * frac;
            mix  = longint'($signed(smp)) + (wet >>> 9);
            if (mix > 32767)
                mix = 32767;
            if (mix < -32768)
                mix = -32768;
            res.sample = mix[15:0];
            delay_ring[ch][wp] = smp;
            wr_ptr[ch] = (wp + 1) % DELAY_DEPTH;
            live_items++;
        end
        if (fe)
        begin
            acc_next = {1'b0, lfo_acc} + step_cfg;
            if (acc_next[32])
                phase_wraps++;
            lfo_acc = acc_next[31:0];
        end
        pending_mix_q.push_back(res);
    endfunction

    // one item on the input stream; returns at the edge that takes it
    task automatic send_sample(input logic [15:0] smp, input logic [2:0] ch,
                               input logic fe);
        int gap;
        gap = ($urandom_range(99) < feed_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= ch;
        s_axis_tlast  <= fe;
        do @(posedge clk); while (!s_axis_tready);
        predict_chorus(smp, ch, fe);
        items_sent++;
    endtask

    // stop feeding and wait until every expected result is back
    task automatic drain_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_mix_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_mix_q.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_mix_q.size());
            error_count++;
            pending_mix_q.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PHASE_STEP: step_cfg  = val[STEP_W-1:0];
            REG_BASE_DELAY: base_cfg  = val[DELAY_W-1:0];
            REG_SWING:      swing_cfg = val[DELAY_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [STEP_W-1:0] step,
                                 input logic [DELAY_W-1:0] base,
                                 input logic [DELAY_W-1:0] swing);
        drain_results();
        write_reg(REG_PHASE_STEP, CFG_W'(step));
        write_reg(REG_BASE_DELAY, CFG_W'(base));
        write_reg(REG_SWING, CFG_W'(swing));
        settings_loaded++;
    endtask

    // reset values; odd channel at phase zero hits the sine peak limit
    task automatic test_reset_defaults();
        feed_gap_pct   = 30;
        sink_stall_pct = 30;
        send_sample(16'h7FFF, 3'd0, 1'b0);
        send_sample(16'h8000, 3'd1, 1'b1);
        send_sample(16'h0001, 3'd0, 1'b0);
        send_sample(16'h5555, 3'd1, 1'b1);
    endtask

    // channels past CHANNELS go straight through, frame end still counts
    task automatic test_pass_through();
        send_sample(16'h8000, 3'd2, 1'b0);
        send_sample(16'h7FFF, 3'd3, 1'b1);
        send_sample(16'hAAAA, 3'd4, 1'b0);
        send_sample(16'h5555, 3'd5, 1'b1);
        send_sample(16'hFFFF, 3'd6, 1'b0);
        send_sample(16'h0000, 3'd7, 1'b1);
        send_sample(16'h1234, 3'd0, 1'b1);
    endtask

    // one-sample delay, zero swing: wet is half the previous sample
    task automatic test_saturation();
        drain_results();
        write_reg(REG_SPARE, 22'h3FFFFF);
        write_reg(REG_PHASE_STEP, CFG_W'(PHASE_STEP_RST));
        // upper bits above the register width are dropped
        write_reg(REG_BASE_DELAY, 22'h380100);
        write_reg(REG_SWING, 22'h380000);
        settings_loaded++;
        send_sample(16'h7FFF, 3'd0, 1'b0);
        send_sample(16'h7FFF, 3'd0, 1'b0);
        send_sample(16'h8000, 3'd0, 1'b0);
        send_sample(16'h8000, 3'd0, 1'b1);
        send_sample(16'h7FFF, 3'd1, 1'b0);
        send_sample(16'h7FFF, 3'd1, 1'b1);
    endtask

    // delay pushed past the top of the ring, then below one sample
    task automatic test_delay_clamp();
        load_settings('0, DELAY_MAX, DELAY_MAX);
        send_sample(16'h4000, 3'd1, 1'b0);
        send_sample(16'hC000, 3'd0, 1'b0);
        send_sample(16'h2000, 3'd1, 1'b1);
        load_settings('0, '0, '0);
        send_sample(16'h7FFF, 3'd0, 1'b0);
        send_sample(16'h8000, 3'd1, 1'b1);
        send_sample(16'h0100, 3'd0, 1'b1);
    endtask

    // largest step with a frame end on every item sweeps the accumulator
    task automatic test_phase_wrap();
        load_settings(STEP_MAX, 19'($urandom_range(2560, 200000)),
                      19'($urandom_range(0, 120000)));
        feed_gap_pct   = 5;
        sink_stall_pct = 5;
        for (int k = 0; k < 320; k++)
            send_sample(rand_sample(), 3'(k % CHANNELS), 1'b1);
    endtask

    // whole frames with random content, some stray items, several settings
    task automatic test_random_traffic();
        logic [STEP_W-1:0]  step;
        logic [DELAY_W-1:0] base, swing;
        int                 n, pause_at;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    step  = 22'($urandom_range(1, 200000));
                    base  = 19'($urandom_range(2560, 200000));
                    swing = 19'($urandom_range(0, 100000));
                end
                1:
                begin
                    step  = '0;
                    base  = DELAY_MAX;
                    swing = DELAY_MAX;
                end
                2:
                begin
                    step  = STEP_MAX;
                    base  = '0;
                    swing = DELAY_MAX;
                end
                4:
                begin
                    step  = 22'($urandom_range(0, 4194303));
                    base  = 19'($urandom_range(0, 524287));
                    swing = '0;
                end
                default:
                begin
                    step  = 22'($urandom_range(0, 4194303));
                    base  = 19'($urandom_range(0, 524287));
                    swing = 19'($urandom_range(0, 524287));
                end
            endcase
            load_settings(step, base, swing);
            // one stretch with no idling on either side
            feed_gap_pct   = (ph == 4) ? 0 : $urandom_range(10, 60);
            sink_stall_pct = (ph == 4) ? 0 : $urandom_range(10, 60);
            pause_at = $urandom_range(20, 70);
            n = 0;
            while (n < 90)
            begin
                if ($urandom_range(99) < 85)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                        send_sample(rand_sample(), 3'(c), c == CHANNELS - 1);
                    n += CHANNELS;
                end
                else
                begin
                    send_sample(rand_sample(), 3'($urandom_range(7)),
                                1'($urandom_range(1)));
                    n++;
                end
                if (n >= pause_at && pause_at >= 0)
                begin
                    drain_results();
                    pause_at = -1;
                end
            end
        end
    endtask

    // output side: random stalls
    initial
    begin : result_sink
        int hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct)
            begin
                hold = pick_gap();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        chorus_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_mix_q.size() == 0)
            begin
                $error("unexpected result: out_sample %0d, out_channel %0d",
                       $signed(m_axis_tdata), m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_mix_q.pop_front();
                results_checked++;
                if (m_axis_tdata !== want.sample)
                begin
                    $error("out_sample: expected %0d, actual %0d",
                           $signed(want.sample), $signed(m_axis_tdata));
                    error_count++;
                end
                if (m_axis_tuser !== want.channel)
                begin
                    $error("out_channel: expected %0d, actual %0d",
                           want.channel, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== want.frame_end)
                begin
                    $error("out_frame_end: expected %0d, actual %0d",
                           want.frame_end, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #15_000_000;
        $display("Run timed out");
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_pass_through();
        test_saturation();
        test_delay_clamp();
        test_phase_wrap();
        test_random_traffic();

        drain_results();
        repeat (20) @(posedge clk);

        $display("Covered %0d items (%0d on live channels) and %0d checked results,",
                 items_sent, live_items, results_checked);
        $display("under %0d register settings incl. delay clamps, with %0d LFO phase wraps",
                 settings_loaded, phase_wraps);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/mdc_pkg.sv
hdl/mdc_ctrl.sv
hdl/mdc_datapath.sv
hdl/modulated_delay_chorus.sv
tb/tb_modulated_delay_chorus.sv
